@@ hdl/regex_infix_to_postfix_top_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the regex infix-to-postfix converter
// Concurrent checks sampled on clk_i, switched off while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef REGEX_INFIX_TO_POSTFIX_TOP_MACROS_SVH
`define REGEX_INFIX_TO_POSTFIX_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RI2P_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RI2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ri2p_pkg.sv @@
// -----------------------------------------------------------------------------
// ri2p_pkg
// Types, character codes and helpers shared by the converter modules.
// -----------------------------------------------------------------------------
package ri2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_BAR   = 8'h7C;  // '|'
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'

  localparam logic [1:0] PREC_STAR = 2'd3;
  localparam logic [1:0] PREC_DOT  = 2'd2;
  localparam logic [1:0] PREC_BAR  = 2'd1;
  localparam logic [1:0] PREC_NONE = 2'd0;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CLOSE    = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_OPEN     = 2'd3
  } err_code_e;

  typedef enum logic [1:0] {
    EMIT_TOP,
    EMIT_SYM,
    EMIT_ERR
  } emit_src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_OPPOP,
    ST_CLOSE,
    ST_FLUSH,
    ST_END
  } state_e;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      clear;
    logic      emit;
    emit_src_e src;
    err_code_e err;
    logic      next_sym;
    logic      set_err;
    logic      finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic phase;        // current symbol is an inserted concatenation
    logic last;
    logic err_seen;
    logic is_open;
    logic is_close;
    logic is_op;
    logic empty;
    logic full;
    logic top_is_open;
    logic prec_ge;      // precedence of top >= precedence of current symbol
    logic can_emit;
    logic out_free;
    logic held_valid;
  } ctrl_sts_t;

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_STAR: p = PREC_STAR;
      CH_DOT:  p = PREC_DOT;
      CH_BAR:  p = PREC_BAR;
      default: p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/regex_infix_to_postfix_top.sv @@
// -----------------------------------------------------------------------------
// regex_infix_to_postfix_top
// Regular-expression infix to postfix converter with explicit concatenation.
// -----------------------------------------------------------------------------
// One character is taken per input beat; tlast marks the last character of an
// expression. An explicit '.' is inserted where two items abut, and the
// operators '*', '.', '|' and parentheses are reordered on a 16-entry operator
// stack. A character is taken only once the previous one, with any inserted
// '.', has been handled. The stack is walked one entry per cycle while the
// output can take a result, and the last character flushes what is left. A
// character that follows an error in the same expression is not processed.
// Every output beat carries tlast on the last result caused by an input beat,
// and the final beat of an expression has the done flag set. Errors
// (unmatched brackets, stack overflow) are reported in-band; the rest of that
// expression is then dropped and its last character gives one beat with done
// set.
// -----------------------------------------------------------------------------
module regex_infix_to_postfix_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,   // expr_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] symbol
  output logic       m_axis_tlast,   // run_last
  output logic [7:0] m_axis_tuser    // [0] symbol_valid, [1] expr_done,
                                     // [3:2] error_code, [7:4] zero
);
  import ri2p_pkg::*;

  `include "regex_infix_to_postfix_top_macros.svh"

  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  logic       sym_valid;
  logic       expr_done;
  logic [1:0] err_code;

  ri2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ri2p_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .char_i             (s_axis_tdata),
    .last_i             (s_axis_tlast),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .out_symbol_o       (m_axis_tdata),
    .out_symbol_valid_o (sym_valid),
    .out_run_last_o     (m_axis_tlast),
    .out_expr_done_o    (expr_done),
    .out_error_code_o   (err_code)
  );

  assign m_axis_tuser = {4'b0000, err_code, expr_done, sym_valid};

  `RI2P_ASSERT_NOW(a_idle_no_held, s_axis_tready, !sts.held_valid, "result held while idle")
  `RI2P_ASSERT_NOW(a_push_not_full, cmd.push, !sts.full, "push onto full stack")
  `RI2P_ASSERT_NOW(a_pop_not_empty, cmd.pop, !sts.empty, "pop from empty stack")
  `RI2P_ASSERT_NEXT(a_end_clears, cmd.finish && sts.last, sts.empty && !sts.err_seen, "not cleared")

endmodule

@@ hdl/ri2p_ctrl.sv @@
// -----------------------------------------------------------------------------
// ri2p_ctrl
// Sequencer: walks each character through concatenation, operator pops,
// parenthesis matching and the end-of-expression flush.
// -----------------------------------------------------------------------------
module ri2p_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ri2p_pkg::ctrl_sts_t sts_i,
  output ri2p_pkg::ctrl_cmd_t cmd_o
);
  import ri2p_pkg::*;

  state_e state_q, state_d;
  logic   adv_go;
  logic   is_operand;

  assign is_operand = !sts_i.is_open && !sts_i.is_close && !sts_i.is_op;

  // current symbol done without error: move on to the next piece of the step
  assign adv_go = sts_i.can_emit && (
      (state_q == ST_FEED  && ((sts_i.is_open && !sts_i.full) || is_operand)) ||
      (state_q == ST_OPPOP && !(!sts_i.empty && sts_i.prec_ge) && !sts_i.full) ||
      (state_q == ST_CLOSE && !sts_i.empty && sts_i.top_is_open));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    if (adv_go) begin
      if (sts_i.phase) begin
        state_d = ST_FEED;
      end else if (sts_i.last) begin
        state_d = ST_FLUSH;
      end else begin
        state_d = ST_END;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_d = sts_i.err_seen ? ST_END : ST_FEED;
          end
        end
        ST_FEED: begin
          if (sts_i.can_emit) begin
            if (sts_i.is_open) begin
              state_d = ST_END;
            end else if (sts_i.is_close) begin
              state_d = ST_CLOSE;
            end else if (sts_i.is_op) begin
              state_d = ST_OPPOP;
            end
          end
        end
        ST_OPPOP: begin
          if (sts_i.can_emit && !(!sts_i.empty && sts_i.prec_ge)) begin
            state_d = ST_END;
          end
        end
        ST_CLOSE: begin
          if (sts_i.can_emit && sts_i.empty) begin
            state_d = ST_END;
          end
        end
        ST_FLUSH: begin
          if (sts_i.can_emit && (sts_i.empty || sts_i.top_is_open)) begin
            state_d = ST_END;
          end
        end
        ST_END: begin
          if (sts_i.out_free) begin
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.src      = EMIT_TOP;
    cmd_o.err      = ERR_NONE;
    in_ready_o     = 1'b0;
    cmd_o.next_sym = adv_go && sts_i.phase;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_FEED: begin
        if (sts_i.can_emit) begin
          if (sts_i.is_open) begin
            if (sts_i.full) begin
              cmd_o.emit    = 1'b1;
              cmd_o.src     = EMIT_ERR;
              cmd_o.err     = ERR_OVERFLOW;
              cmd_o.set_err = 1'b1;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else if (is_operand) begin
            cmd_o.emit = 1'b1;
            cmd_o.src  = EMIT_SYM;
          end
        end
      end
      ST_OPPOP: begin
        if (sts_i.can_emit) begin
          if (!sts_i.empty && sts_i.prec_ge) begin
            cmd_o.pop  = 1'b1;
            cmd_o.emit = 1'b1;
          end else if (sts_i.full) begin
            cmd_o.emit    = 1'b1;
            cmd_o.src     = EMIT_ERR;
            cmd_o.err     = ERR_OVERFLOW;
            cmd_o.set_err = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        if (sts_i.can_emit) begin
          if (sts_i.empty) begin
            cmd_o.emit    = 1'b1;
            cmd_o.src     = EMIT_ERR;
            cmd_o.err     = ERR_CLOSE;
            cmd_o.set_err = 1'b1;
          end else begin
            cmd_o.pop  = 1'b1;
            cmd_o.emit = !sts_i.top_is_open;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.can_emit && !sts_i.empty) begin
          if (sts_i.top_is_open) begin
            // discard the rest of the stack
            cmd_o.clear   = 1'b1;
            cmd_o.emit    = 1'b1;
            cmd_o.src     = EMIT_ERR;
            cmd_o.err     = ERR_OPEN;
            cmd_o.set_err = 1'b1;
          end else begin
            cmd_o.pop  = 1'b1;
            cmd_o.emit = 1'b1;
          end
        end
      end
      ST_END: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/ri2p_datapath.sv @@
// -----------------------------------------------------------------------------
// ri2p_datapath
// Operator stack, expression state, a one-entry hold for the newest result
// and the output register of the master side.
// -----------------------------------------------------------------------------
module ri2p_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ri2p_pkg::ctrl_cmd_t cmd_i,
  output ri2p_pkg::ctrl_sts_t sts_o,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_symbol_o,
  output logic                out_symbol_valid_o,
  output logic                out_run_last_o,
  output logic                out_expr_done_o,
  output logic [1:0]          out_error_code_o
);
  import ri2p_pkg::*;

  logic [7:0]       stack_q [STACK_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       prev_q;
  logic             have_prev_q;
  logic             err_seen_q;
  logic [7:0]       char_q;
  logic             last_q;
  logic             phase_q;

  logic             held_valid_q;
  logic [7:0]       held_sym_q;
  logic             held_sv_q;
  err_code_e        held_err_q;

  logic             out_valid_q;
  logic [7:0]       out_sym_q;
  logic             out_sv_q;
  logic             out_last_q;
  logic             out_done_q;
  err_code_e        out_err_q;

  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] push_idx;
  logic [7:0]       top_sym;
  logic [7:0]       cur_sym;
  logic             cat_ins;
  logic             out_free;
  logic             full;
  logic             empty;
  logic [7:0]       emit_sym;
  logic             emit_sv;
  err_code_e        emit_err;

  assign top_idx  = count_q[IDX_W-1:0] - IDX_W'(1);
  assign push_idx = count_q[IDX_W-1:0];
  assign top_sym  = stack_q[top_idx];
  assign cur_sym  = phase_q ? CH_DOT : char_q;
  assign full     = (count_q == CNT_W'(STACK_DEPTH));
  assign empty    = (count_q == '0);
  assign out_free = !out_valid_q || out_ready_i;

  assign cat_ins = have_prev_q &&
                   !(prev_q inside {CH_BAR, CH_DOT, CH_OPEN}) &&
                   !(char_i inside {CH_CLOSE, CH_BAR, CH_STAR, CH_DOT});

  always_comb begin
    sts_o.phase       = phase_q;
    sts_o.last        = last_q;
    sts_o.err_seen    = err_seen_q;
    sts_o.is_open     = (cur_sym == CH_OPEN);
    sts_o.is_close    = (cur_sym == CH_CLOSE);
    sts_o.is_op       = cur_sym inside {CH_BAR, CH_STAR, CH_DOT};
    sts_o.empty       = empty;
    sts_o.full        = full;
    sts_o.top_is_open = (top_sym == CH_OPEN);
    sts_o.prec_ge     = (prec(top_sym) >= prec(cur_sym));
    sts_o.can_emit    = !held_valid_q || out_free;
    sts_o.out_free    = out_free;
    sts_o.held_valid  = held_valid_q;
  end

  always_comb begin
    case (cmd_i.src)
      EMIT_TOP: begin
        emit_sym = top_sym;
        emit_sv  = 1'b1;
        emit_err = ERR_NONE;
      end
      EMIT_SYM: begin
        emit_sym = cur_sym;
        emit_sv  = 1'b1;
        emit_err = ERR_NONE;
      end
      default: begin
        emit_sym = 8'h00;
        emit_sv  = 1'b0;
        emit_err = cmd_i.err;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear || (cmd_i.finish && last_q)) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_q[push_idx] <= cur_sym;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= char_i;
    end
    if (cmd_i.emit) begin
      held_sym_q <= emit_sym;
      held_sv_q  <= emit_sv;
      held_err_q <= emit_err;
    end
    // hand the held result on when a newer one arrives or the step ends
    if ((cmd_i.emit || cmd_i.finish) && held_valid_q) begin
      out_sym_q  <= held_sym_q;
      out_sv_q   <= held_sv_q;
      out_err_q  <= held_err_q;
      out_last_q <= cmd_i.finish;
      out_done_q <= cmd_i.finish && last_q;
    end else if (cmd_i.finish && last_q) begin
      out_sym_q  <= 8'h00;
      out_sv_q   <= 1'b0;
      out_err_q  <= ERR_NONE;
      out_last_q <= 1'b1;
      out_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      prev_q       <= 8'h00;
      have_prev_q  <= 1'b0;
      err_seen_q   <= 1'b0;
      last_q       <= 1'b0;
      phase_q      <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        last_q <= last_i;
        if (!err_seen_q) begin
          phase_q     <= cat_ins;
          prev_q      <= char_i;
          have_prev_q <= 1'b1;
        end
      end else if (cmd_i.next_sym) begin
        phase_q <= 1'b0;
      end
      if (cmd_i.finish && last_q) begin
        prev_q      <= 8'h00;
        have_prev_q <= 1'b0;
        err_seen_q  <= 1'b0;
      end else if (cmd_i.set_err) begin
        err_seen_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        held_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        held_valid_q <= 1'b0;
      end
      if (((cmd_i.emit || cmd_i.finish) && held_valid_q) || (cmd_i.finish && last_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_symbol_o       = out_sym_q;
  assign out_symbol_valid_o = out_sv_q;
  assign out_run_last_o     = out_last_q;
  assign out_expr_done_o    = out_done_q;
  assign out_error_code_o   = out_err_q;

endmodule

@@ sim/regex_infix_to_postfix_top_test.sv @@
// -----------------------------------------------------------------------------
// regex_infix_to_postfix_top_test
// Self-checking bench for the infix-to-postfix regex converter. Characters go
// in on the input stream with random gaps. A shunting-yard model of the block
// predicts every output beat, including the inserted concatenations and the
// in-band error beats. A checker compares each output beat with the oldest
// prediction. Directed expressions, stack limit cases and random well-formed
// and broken ones are run; random gaps and output stalls stop back to back.
// -----------------------------------------------------------------------------
module regex_infix_to_postfix_top_test;
  import ri2p_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct packed {
    logic [7:0] symbol;
    logic       sym_valid;
    logic       run_last;
    logic       expr_done;
    err_code_e  err;
  } postfix_beat_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [7:0] m_axis_tuser;

  // converter model state
  logic [7:0] op_stk [STACK_DEPTH];
  int         op_cnt;
  logic [7:0] prev_chr;
  bit         have_prev_chr;
  bit         expr_failed;

  postfix_beat_t step_beats[$];
  postfix_beat_t expected_beats[$];
  logic [7:0]    expr_chars[$];

  bit            idle_en = 1'b1;
  int            ready_hold = 0;
  int            sent_items = 0;
  int            fail_count = 0;
  int            quiet_cycles = 0;
  postfix_beat_t want;
  bit            bad;

  regex_infix_to_postfix_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model of the converter
  // ---------------------------------------------------------------------------
  function automatic logic [1:0] op_rank(input logic [7:0] c);
    if (c == CH_STAR) return PREC_STAR;
    if (c == CH_DOT) return PREC_DOT;
    if (c == CH_BAR) return PREC_BAR;
    return PREC_NONE;
  endfunction

  function automatic void emit_beat(input logic [7:0] s, input logic v, input err_code_e e);
    postfix_beat_t b;
    b.symbol    = s;
    b.sym_valid = v;
    b.run_last  = 1'b0;
    b.expr_done = 1'b0;
    b.err       = e;
    step_beats.insert(step_beats.size(), b);
  endfunction

  function automatic bit push_op(input logic [7:0] c);
    if (op_cnt >= STACK_DEPTH) begin
      emit_beat(8'h00, 1'b0, ERR_OVERFLOW);
      return 1'b0;
    end
    op_stk[op_cnt] = c;
    op_cnt++;
    return 1'b1;
  endfunction

  function automatic bit shunt_symbol(input logic [7:0] c);
    bit found;
    found = 1'b0;
    if (c == CH_OPEN) return push_op(c);
    if (c == CH_CLOSE) begin
      while (!found) begin
        if (op_cnt == 0) begin
          emit_beat(8'h00, 1'b0, ERR_CLOSE);
          return 1'b0;
        end
        op_cnt--;
        if (op_stk[op_cnt] == CH_OPEN) found = 1'b1;
        else emit_beat(op_stk[op_cnt], 1'b1, ERR_NONE);
      end
      return 1'b1;
    end
    if (c == CH_BAR || c == CH_STAR || c == CH_DOT) begin
      while (op_cnt > 0 && op_rank(op_stk[op_cnt - 1]) >= op_rank(c)) begin
        op_cnt--;
        emit_beat(op_stk[op_cnt], 1'b1, ERR_NONE);
      end
      return push_op(c);
    end
    emit_beat(c, 1'b1, ERR_NONE);
    return 1'b1;
  endfunction

  function automatic bit flush_ops();
    while (op_cnt > 0) begin
      op_cnt--;
      if (op_stk[op_cnt] == CH_OPEN) begin
        op_cnt = 0;
        emit_beat(8'h00, 1'b0, ERR_OPEN);
        return 1'b0;
      end
      emit_beat(op_stk[op_cnt], 1'b1, ERR_NONE);
    end
    return 1'b1;
  endfunction

  function automatic void clear_converter();
    op_cnt        = 0;
    prev_chr      = 8'h00;
    have_prev_chr = 1'b0;
    expr_failed   = 1'b0;
  endfunction

  function automatic void predict_postfix(input logic [7:0] c, input logic last);
    bit            ok;
    postfix_beat_t b;
    step_beats.delete();
    if (!expr_failed) begin
      ok = 1'b1;
      // explicit concatenation between abutting items
      if (have_prev_chr && prev_chr != CH_BAR && prev_chr != CH_DOT && prev_chr != CH_OPEN &&
          c != CH_CLOSE && c != CH_BAR && c != CH_STAR && c != CH_DOT)
        ok = shunt_symbol(CH_DOT);
      if (ok) ok = shunt_symbol(c);
      if (ok && last) ok = flush_ops();
      if (!ok) expr_failed = 1'b1;
      prev_chr      = c;
      have_prev_chr = 1'b1;
    end
    if (last && step_beats.size() == 0) emit_beat(8'h00, 1'b0, ERR_NONE);
    if (step_beats.size() > 0) begin
      b = step_beats.pop_back();
      b.run_last  = 1'b1;
      b.expr_done = last;
      step_beats.insert(step_beats.size(), b);
    end
    foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
    if (last) clear_converter();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_char(input logic [7:0] c);
    expr_chars.insert(expr_chars.size(), c);
  endfunction

  function automatic bit is_operator(input logic [7:0] c);
    return c == CH_STAR || c == CH_DOT || c == CH_BAR || c == CH_OPEN || c == CH_CLOSE;
  endfunction

  function automatic logic [7:0] random_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_operator(c));
    return c;
  endfunction

  function automatic logic [7:0] random_operator();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: c = CH_STAR;
      1: c = CH_DOT;
      2: c = CH_BAR;
      3: c = CH_OPEN;
      default: c = CH_CLOSE;
    endcase
    return c;
  endfunction

  // balanced expression, operand where one is due, shallow nesting
  function automatic void build_well_formed();
    int target;
    int depth;
    bit want_operand;
    expr_chars.delete();
    target       = $urandom_range(1, 14);
    depth        = 0;
    want_operand = 1'b1;
    while (expr_chars.size() < target) begin
      if (want_operand) begin
        if (depth < 4 && $urandom_range(0, 3) == 0) begin
          add_char(CH_OPEN);
          depth++;
        end else begin
          add_char(random_operand());
          want_operand = 1'b0;
        end
      end else begin
        case ($urandom_range(0, 5))
          0: add_char(CH_STAR);
          1: begin
            add_char(CH_BAR);
            want_operand = 1'b1;
          end
          2: if (depth > 0) begin
            add_char(CH_CLOSE);
            depth--;
          end
          3: begin
            add_char(CH_DOT);
            want_operand = 1'b1;
          end
          default: want_operand = 1'b1;  // implicit concatenation
        endcase
      end
    end
    if (want_operand) add_char(random_operand());
    while (depth > 0) begin
      add_char(CH_CLOSE);
      depth--;
    end
  endfunction

  function automatic void build_noise();
    int len;
    expr_chars.delete();
    len = $urandom_range(1, 10);
    repeat (len) begin
      if ($urandom_range(0, 1) == 0) add_char(random_operator());
      else add_char(8'($urandom_range(0, 255)));
    end
  endfunction

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_postfix(c, last);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_expr();
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    expr_chars.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_expr();
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_operand_extremes();
    send_char(8'h00, 1'b0);  // code zero is a plain operand
    send_char(8'hFF, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_all_operators();
    send_text("(a|b)*.c");
    wait_for_drain();
  endtask

  task automatic test_bracket_errors();
    send_text("a)b");  // unmatched close, rest of expression dropped
    send_text("(a");   // unmatched open found while flushing
    send_text("()");   // final step with nothing to emit
    wait_for_drain();
  endtask

  task automatic test_stack_limits();
    // exactly full, then one push too many by bracket and by operator
    expr_chars.delete();
    repeat (STACK_DEPTH) add_char(CH_OPEN);
    add_char("a");
    repeat (STACK_DEPTH) add_char(CH_CLOSE);
    send_expr();
    expr_chars.delete();
    repeat (STACK_DEPTH + 1) add_char(CH_OPEN);
    add_char("a");
    send_expr();
    expr_chars.delete();
    repeat (STACK_DEPTH - 1) add_char(CH_OPEN);
    add_char("a");
    add_char(CH_BAR);
    add_char("b");
    add_char(CH_STAR);
    send_expr();
    wait_for_drain();
  endtask

  task automatic test_random_expressions(input int n_items);
    int  stop_at;
    bit  paused;
    stop_at = sent_items + n_items;
    paused  = 1'b0;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 4) == 0) build_noise();
      else build_well_formed();
      send_expr();
      // hold the input once until the output side has caught up
      if (!paused && sent_items > stop_at - n_items / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end
    wait_for_drain();
  endtask

  task automatic test_random_back_to_back(input int n_items);
    int stop_at;
    idle_en = 1'b0;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 4) == 0) build_noise();
      else build_well_formed();
      send_expr();
    end
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, then check every beat
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold    <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      ready_hold    <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected output beat: sym %h last %b user %h",
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        bad  = (m_axis_tdata !== want.symbol) || (m_axis_tuser[0] !== want.sym_valid) ||
               (m_axis_tlast !== want.run_last) || (m_axis_tuser[1] !== want.expr_done) ||
               (m_axis_tuser[3:2] !== want.err) || (m_axis_tuser[7:4] !== 4'h0);
        if (bad) begin
          if (fail_count < 10)
            $display("beat mismatch: exp sym %h vld %b last %b done %b err %0d | %s",
                     want.symbol, want.sym_valid, want.run_last, want.expr_done, want.err,
                     $sformatf("got sym %h last %b user %h",
                               m_axis_tdata, m_axis_tlast, m_axis_tuser));
          fail_count++;
        end
      end
    end
  end

  // count quiet cycles, in which no beat moves on either side, and fail at the limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("regex_infix_to_postfix_top_test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clear_converter();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_operand_extremes();
    test_all_operators();
    test_bracket_errors();
    test_stack_limits();
    test_random_expressions(120);
    test_random_back_to_back(45);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_beats.size() != 0) fail_count++;
    if (fail_count == 0) $display("regex_infix_to_postfix_top_test passed");
    else $display("regex_infix_to_postfix_top_test failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ri2p_pkg.sv
hdl/ri2p_ctrl.sv
hdl/ri2p_datapath.sv
hdl/regex_infix_to_postfix_top.sv
sim/regex_infix_to_postfix_top_test.sv
